// ===== hdl/vgsp_pkg.sv =====
// shared types and constants for the voxel grid shape painter
// no dependencies; compiled first
`default_nettype none

package vgsp_pkg;

  // field widths of the request, result and configuration port
  localparam int REQ_W      = 3;
  localparam int COORD_W    = 10;
  localparam int RADIUS_W   = 9;
  localparam int SIZE_W     = 6;
  localparam int COLOR_W    = 8;
  localparam int COUNT_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // signed width that holds a center plus or minus a radius
  localparam int BOUND_W = 12;
  // width of one squared distance term
  localparam int SQ_W    = 20;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);

  typedef logic signed [BOUND_W-1:0] bound_t;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PUT_VOXEL  = 3'd0,
    REQ_CUT_VOXEL  = 3'd1,
    REQ_PUT_BOX    = 3'd2,
    REQ_CUT_BOX    = 3'd3,
    REQ_PUT_SPHERE = 3'd4,
    REQ_CUT_SPHERE = 3'd5,
    REQ_READ_VOXEL = 3'd6
  } req_code_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X      = 3'd0,
    CFG_SIZE_Y      = 3'd1,
    CFG_SIZE_Z      = 3'd2,
    CFG_PAINT_RED   = 3'd3,
    CFG_PAINT_GREEN = 3'd4,
    CFG_PAINT_BLUE  = 3'd5,
    CFG_PAINT_ALPHA = 3'd6
  } cfg_index_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_START,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_TEST,
    ST_BOX,
    ST_READ,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/vgsp_ifs.sv =====
// request and result channel interfaces (valid/ready with payload)
// depends on vgsp_pkg
`default_nettype none

interface vgsp_req_if;
  import vgsp_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic signed [COORD_W-1:0]  first_x;
  logic signed [COORD_W-1:0]  last_x;
  logic signed [COORD_W-1:0]  first_y;
  logic signed [COORD_W-1:0]  last_y;
  logic signed [COORD_W-1:0]  first_z;
  logic signed [COORD_W-1:0]  last_z;
  logic [RADIUS_W-1:0]        radius;

  modport source (
    output valid, req_type, first_x, last_x, first_y, last_y, first_z, last_z, radius,
    input  ready
  );
  modport sink (
    input  valid, req_type, first_x, last_x, first_y, last_y, first_z, last_z, radius,
    output ready
  );
endinterface

interface vgsp_rsp_if;
  import vgsp_pkg::*;

  logic               valid;
  logic               ready;
  logic               inside_grid;
  logic               voxel_shown;
  logic [COLOR_W-1:0] voxel_red;
  logic [COLOR_W-1:0] voxel_green;
  logic [COLOR_W-1:0] voxel_blue;
  logic [COLOR_W-1:0] voxel_alpha;
  logic [COUNT_W-1:0] written_count;

  modport source (
    output valid, inside_grid, voxel_shown, voxel_red, voxel_green, voxel_blue,
           voxel_alpha, written_count,
    input  ready
  );
  modport sink (
    input  valid, inside_grid, voxel_shown, voxel_red, voxel_green, voxel_blue,
           voxel_alpha, written_count,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/vgsp_ram.sv =====
// generic single-port ram with registered read
// no dependencies
`default_nettype none

module vgsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read on one address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== hdl/voxel_grid_shape_painter.sv =====
// voxel grid shape painter: top level with sequencer, shared squarer and voxel store
// depends on vgsp_pkg, vgsp_req_if, vgsp_rsp_if and vgsp_ram
//
// Usage: requests arrive on the req channel, one result per request leaves on rsp.
// Configuration (grid size, paint color) is written through cfg_we / cfg_index /
// cfg_data while the block is idle; index 7 is ignored.
// After reset all 2^(clog2(MAX_X)+clog2(MAX_Y)+clog2(MAX_Z)) store entries (32768 at the
// defaults) are swept to zero, one entry per cycle; req.ready stays low during the sweep.
// One request is worked at a time. From the req transfer to rsp.valid it passes through:
//   put/cut voxel, put/cut box: setup, start, then one store write per in-grid voxel
//   put/cut sphere: setup, start, then a squarer step and a test per voxel of the clamped
//     bounding box, plus a squarer step per row and per plane of that box (shared squarer)
//   read voxel: setup, start and read; unused request code: setup and start
// The rate is set by the single-port store (one voxel write per cycle) and by the
// single squarer that evaluates dx, dy and dz one after another.
// The result sits in an output register; a new request is taken while it waits. If
// rsp.ready stays low, the next finished result holds in the sequencer until the
// register frees.
`default_nettype none

module voxel_grid_shape_painter #(
  parameter int MAX_X = 32,
  parameter int MAX_Y = 32,
  parameter int MAX_Z = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [vgsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vgsp_pkg::CFG_DATA_W-1:0] cfg_data,
  vgsp_req_if.sink                        req,
  vgsp_rsp_if.source                      rsp
);
  import vgsp_pkg::*;

  localparam int XW          = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int YW          = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int ZW          = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
  localparam int AW          = XW + YW + ZW;
  localparam int STORE_DEPTH = 1 << AW;
  localparam int DIST_W      = SQ_W + 2;

  localparam bound_t NX_MAX = bound_t'(MAX_X);
  localparam bound_t NY_MAX = bound_t'(MAX_Y);
  localparam bound_t NZ_MAX = bound_t'(MAX_Z);

  function automatic bound_t clamp_lo(input bound_t v);
    return (v < bound_t'(0)) ? bound_t'(0) : v;
  endfunction

  function automatic bound_t clamp_hi(input bound_t v, input bound_t lim);
    return (v > lim) ? lim : v;
  endfunction

  // configuration registers
  logic [SIZE_W-1:0]  size_x, size_y, size_z;
  logic [COLOR_W-1:0] paint_red, paint_green, paint_blue, paint_alpha;

  // sequencer
  state_t state, state_next;
  logic [AW-1:0] clr_cnt;

  // latched request
  logic [REQ_W-1:0]          op;
  logic signed [COORD_W-1:0] fx, lx, fy, ly, fz, lz;
  logic [RADIUS_W-1:0]       rad;

  // scan bounds and position
  bound_t lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  logic [XW-1:0] x;
  logic [YW-1:0] y;
  logic [ZW-1:0] z;

  // squarer and distance terms
  bound_t                         mul_a;
  logic signed [2*BOUND_W-1:0]    mul_p;
  logic [SQ_W-1:0]                sq_val;
  logic [SQ_W-1:0]                r2, sqx, sqy, sqz;
  logic [DIST_W-1:0]              dist_sq;
  logic                           in_sphere;

  // working result
  logic [COUNT_W-1:0]   count;
  logic                 res_inside, res_shown;
  logic [4*COLOR_W-1:0] res_color;

  // output register
  logic                 out_valid;
  logic                 out_inside, out_shown;
  logic [4*COLOR_W-1:0] out_color;
  logic [COUNT_W-1:0]   out_count;

  // store ports
  logic [AW-1:0]        mem_addr;
  logic                 shown_we, col_we;
  logic [0:0]           shown_wd, shown_rd;
  logic [4*COLOR_W-1:0] col_wd, col_rd;

  // control decode
  logic   is_sphere, is_box, is_put, vox_write, out_free, empty;
  logic   x_last, y_last, z_last, scan_end;
  bound_t n_x, n_y, n_z;
  bound_t fx_b, fy_b, fz_b, rad_b;
  bound_t lo_x_next, hi_x_next, lo_y_next, hi_y_next, lo_z_next, hi_z_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x      <= SIZE_RESET;
      size_y      <= SIZE_RESET;
      size_z      <= SIZE_RESET;
      paint_red   <= '0;
      paint_green <= '0;
      paint_blue  <= '0;
      paint_alpha <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIZE_X:      size_x      <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_Y:      size_y      <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_Z:      size_z      <= cfg_data[SIZE_W-1:0];
        CFG_PAINT_RED:   paint_red   <= cfg_data[COLOR_W-1:0];
        CFG_PAINT_GREEN: paint_green <= cfg_data[COLOR_W-1:0];
        CFG_PAINT_BLUE:  paint_blue  <= cfg_data[COLOR_W-1:0];
        CFG_PAINT_ALPHA: paint_alpha <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // grid extent in use, limited by the store
  assign n_x = (bound_t'(size_x) > NX_MAX) ? NX_MAX : bound_t'(size_x);
  assign n_y = (bound_t'(size_y) > NY_MAX) ? NY_MAX : bound_t'(size_y);
  assign n_z = (bound_t'(size_z) > NZ_MAX) ? NZ_MAX : bound_t'(size_z);

  // request decode
  assign is_sphere = (op == REQ_PUT_SPHERE) || (op == REQ_CUT_SPHERE);
  assign is_box    = (op == REQ_PUT_BOX) || (op == REQ_CUT_BOX);
  assign is_put    = (op == REQ_PUT_VOXEL) || (op == REQ_PUT_BOX) || (op == REQ_PUT_SPHERE);

  assign fx_b  = bound_t'(fx);
  assign fy_b  = bound_t'(fy);
  assign fz_b  = bound_t'(fz);
  assign rad_b = bound_t'(rad);

  // clamped scan bounds; a single voxel is a box of one
  assign lo_x_next = clamp_lo(is_sphere ? fx_b - rad_b : fx_b);
  assign lo_y_next = clamp_lo(is_sphere ? fy_b - rad_b : fy_b);
  assign lo_z_next = clamp_lo(is_sphere ? fz_b - rad_b : fz_b);
  assign hi_x_next = clamp_hi(is_sphere ? fx_b + rad_b : (is_box ? bound_t'(lx) : fx_b),
                              n_x - bound_t'(1));
  assign hi_y_next = clamp_hi(is_sphere ? fy_b + rad_b : (is_box ? bound_t'(ly) : fy_b),
                              n_y - bound_t'(1));
  assign hi_z_next = clamp_hi(is_sphere ? fz_b + rad_b : (is_box ? bound_t'(lz) : fz_b),
                              n_z - bound_t'(1));

  assign empty = (lo_x > hi_x) || (lo_y > hi_y) || (lo_z > hi_z);

  // scan position
  assign x_last   = (x == hi_x[XW-1:0]);
  assign y_last   = (y == hi_y[YW-1:0]);
  assign z_last   = (z == hi_z[ZW-1:0]);
  assign scan_end = x_last && y_last && z_last;

  // shared squarer
  always_comb begin
    case (state)
      ST_SETUP: mul_a = rad_b;
      ST_SQ_X:  mul_a = bound_t'(x) - fx_b;
      ST_SQ_Y:  mul_a = bound_t'(y) - fy_b;
      ST_SQ_Z:  mul_a = bound_t'(z) - fz_b;
      default:  mul_a = '0;
    endcase
  end
  assign mul_p  = mul_a * mul_a;
  assign sq_val = mul_p[SQ_W-1:0];

  // sphere membership test
  assign dist_sq   = DIST_W'(sqx) + DIST_W'(sqy) + DIST_W'(sqz);
  assign in_sphere = (dist_sq <= DIST_W'(r2));

  assign vox_write = (state == ST_BOX) || ((state == ST_TEST) && in_sphere);
  assign out_free  = !out_valid || rsp.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == {AW{1'b1}}) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req.valid) state_next = ST_SETUP;
      end
      ST_SETUP: state_next = ST_START;
      ST_START: begin
        case (op)
          REQ_READ_VOXEL: state_next = empty ? ST_DONE : ST_READ;
          REQ_PUT_SPHERE, REQ_CUT_SPHERE: state_next = empty ? ST_DONE : ST_SQ_X;
          REQ_PUT_VOXEL, REQ_CUT_VOXEL, REQ_PUT_BOX, REQ_CUT_BOX:
            state_next = empty ? ST_DONE : ST_BOX;
          default: state_next = ST_DONE;
        endcase
      end
      ST_SQ_X: state_next = ST_SQ_Y;
      ST_SQ_Y: state_next = ST_SQ_Z;
      ST_SQ_Z: state_next = ST_TEST;
      ST_TEST: begin
        if (scan_end) state_next = ST_DONE;
        else if (!z_last) state_next = ST_SQ_Z;
        else if (!y_last) state_next = ST_SQ_Y;
        else state_next = ST_SQ_X;
      end
      ST_BOX: begin
        if (scan_end) state_next = ST_DONE;
      end
      ST_READ: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register and clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if ((state == ST_CLEAR) && (clr_cnt != {AW{1'b1}})) clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          op  <= req.req_type;
          fx  <= req.first_x;
          lx  <= req.last_x;
          fy  <= req.first_y;
          ly  <= req.last_y;
          fz  <= req.first_z;
          lz  <= req.last_z;
          rad <= req.radius;
        end
      end
      ST_SETUP: begin
        lo_x <= lo_x_next;
        hi_x <= hi_x_next;
        lo_y <= lo_y_next;
        hi_y <= hi_y_next;
        lo_z <= lo_z_next;
        hi_z <= hi_z_next;
        r2   <= sq_val;
      end
      ST_START: begin
        x          <= lo_x[XW-1:0];
        y          <= lo_y[YW-1:0];
        z          <= lo_z[ZW-1:0];
        count      <= '0;
        res_inside <= 1'b0;
        res_shown  <= 1'b0;
        res_color  <= '0;
      end
      ST_SQ_X: sqx <= sq_val;
      ST_SQ_Y: sqy <= sq_val;
      ST_SQ_Z: sqz <= sq_val;
      ST_TEST, ST_BOX: begin
        if (vox_write && (count != {COUNT_W{1'b1}})) count <= count + COUNT_W'(1);
        // z innermost, then y, then x
        if (!z_last) begin
          z <= z + ZW'(1);
        end else begin
          z <= lo_z[ZW-1:0];
          if (!y_last) begin
            y <= y + YW'(1);
          end else begin
            y <= lo_y[YW-1:0];
            if (!x_last) x <= x + XW'(1);
          end
        end
      end
      ST_READ: begin
        res_inside <= 1'b1;
        res_shown  <= shown_rd[0];
        res_color  <= col_rd;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      out_inside <= res_inside;
      out_shown  <= res_shown;
      out_color  <= res_color;
      out_count  <= count;
    end
  end

  assign req.ready         = (state == ST_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.inside_grid   = out_inside;
  assign rsp.voxel_shown   = out_shown;
  assign rsp.voxel_red     = out_color[COLOR_W-1:0];
  assign rsp.voxel_green   = out_color[2*COLOR_W-1:COLOR_W];
  assign rsp.voxel_blue    = out_color[3*COLOR_W-1:2*COLOR_W];
  assign rsp.voxel_alpha   = out_color[4*COLOR_W-1:3*COLOR_W];
  assign rsp.written_count = out_count;

  // store address: sweep, first corner, or scan position
  always_comb begin
    case (state)
      ST_CLEAR: mem_addr = clr_cnt;
      ST_START: mem_addr = {lo_x[XW-1:0], lo_y[YW-1:0], lo_z[ZW-1:0]};
      default:  mem_addr = {x, y, z};
    endcase
  end

  // cut touches only the shown bit, so color keeps its own store
  assign shown_we = (state == ST_CLEAR) || vox_write;
  assign shown_wd = (state == ST_CLEAR) ? 1'b0 : is_put;
  assign col_we   = (state == ST_CLEAR) || (vox_write && is_put);
  assign col_wd   = (state == ST_CLEAR) ? '0 :
                    {paint_alpha, paint_blue, paint_green, paint_red};

  vgsp_ram #(
    .WIDTH (1),
    .DEPTH (STORE_DEPTH)
  ) u_shown_ram (
    .clk   (clk),
    .we    (shown_we),
    .addr  (mem_addr),
    .wdata (shown_wd),
    .rdata (shown_rd)
  );

  vgsp_ram #(
    .WIDTH (4 * COLOR_W),
    .DEPTH (STORE_DEPTH)
  ) u_color_ram (
    .clk   (clk),
    .we    (col_we),
    .addr  (mem_addr),
    .wdata (col_wd),
    .rdata (col_rd)
  );

  // write count never drops while a scan runs
  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BOX || state == ST_TEST) |=> count >= $past(count))
    else $error("write count dropped during scan");

  // a result appears only out of the done state
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside done state");

  // no request transfer before the clear sweep has finished
  a_clear_first: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |-> clr_cnt == {AW{1'b1}})
    else $error("request taken before store clear finished");

endmodule

`default_nettype wire
